>>> sv/lups_pkg.sv
package lups_pkg;

	localparam int MaxOrderDef  = 16;
	localparam int ValueBitsDef = 32;
	localparam int FracBits     = 16;

	// divider operation kinds
	typedef enum logic [1:0] {
		DIV_FACTOR = 2'd0,
		DIV_SOLVE  = 2'd1,
		DIV_NONE   = 2'd2
	} div_kind_t;

	// control bundle from sequencer to divider
	typedef struct packed {
		logic      go;
		div_kind_t kind;
	} div_ctl_t;

endpackage

>>> sv/lups_div.sv
// Signed fixed-point divide, one quotient bit per cycle, rounded to nearest
// with ties away from zero, saturating.
module lups_div import lups_pkg::*; #(
	parameter int ValueBits = ValueBitsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  div_ctl_t                    ctl,
	input  logic signed [ValueBits-1:0] num,
	input  logic signed [ValueBits-1:0] den,
	output logic                        done,
	output logic signed [ValueBits-1:0] quo
);
	localparam int NumBits = ValueBits + FracBits;
	localparam int CntBits = $clog2(NumBits + 1);
	localparam logic [NumBits:0] VMaxW = {{(FracBits+1){1'b0}}, 1'b0, {(ValueBits-1){1'b1}}};

	logic [NumBits-1:0] n_q;
	logic [ValueBits:0] r_q;
	logic [ValueBits-1:0] d_q;
	logic [NumBits:0]   q_q;
	logic               neg_q;
	logic               zero_q;
	logic               nz_q;
	logic               busy_q;
	logic [CntBits-1:0] cnt_q;

	logic [ValueBits:0]   r_sh;
	logic [ValueBits:0]   r_nx;
	logic                 ge;
	logic [ValueBits-1:0] ma;
	logic [ValueBits-1:0] mb;
	logic [ValueBits:0]   twice_r;
	logic [NumBits:0]     q_rnd;
	logic signed [ValueBits-1:0] res;

	assign ma = num[ValueBits-1] ? ValueBits'(-num) : ValueBits'(num);
	assign mb = den[ValueBits-1] ? ValueBits'(-den) : ValueBits'(den);

	// restoring step
	always_comb begin
		r_sh = {r_q[ValueBits-1:0], n_q[NumBits-1]};
		ge   = r_sh >= {1'b0, d_q};
		r_nx = ge ? r_sh - {1'b0, d_q} : r_sh;
	end

	// rounding and saturation
	always_comb begin
		twice_r = {r_q[ValueBits-1:0], 1'b0};
		q_rnd   = (twice_r >= {1'b0, d_q}) ? q_q + 1'b1 : q_q;
		if (zero_q) begin
			res = nz_q ? (neg_q ? {1'b1, {(ValueBits-1){1'b0}}}
			                    : {1'b0, {(ValueBits-1){1'b1}}}) : '0;
		end else if (q_rnd > VMaxW) begin
			res = neg_q ? {1'b1, {(ValueBits-1){1'b0}}} : {1'b0, {(ValueBits-1){1'b1}}};
		end else begin
			res = neg_q ? ValueBits'(-q_rnd[ValueBits-1:0]) : q_rnd[ValueBits-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.go) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(NumBits);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			n_q    <= {ma, {FracBits{1'b0}}};
			d_q    <= mb;
			r_q    <= '0;
			q_q    <= '0;
			neg_q  <= num[ValueBits-1] ^ den[ValueBits-1];
			zero_q <= (mb == '0);
			nz_q   <= (ma != '0);
		end else if (busy_q && cnt_q != '0) begin
			r_q <= r_nx;
			q_q <= {q_q[NumBits-1:0], ge};
			n_q <= {n_q[NumBits-2:0], 1'b0};
		end
		if (busy_q && cnt_q == '0) quo <= res;
	end

endmodule

>>> sv/lu_pivot_linear_solver_top.sv
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+-------------------------
// request   | value                                  | start & !busy
// result    | solution, position, last, singular     | strobe, one cycle
// config    | size_in_use_we, size_in_use_wdata      | size_in_use_we
//
// Loading takes one element per cycle while start is high. After the last
// element busy stays high for the scale pass, the O(n^3) elimination on one
// multiply-subtract unit plus a bit-serial divider that holds the sequencer
// for each divide, n(n+1)/2 divides in all, and the substitutions; then n
// results go out one per cycle. Reset clears control state only; the
// receiver cannot stall, so results go out unconditionally.
module lu_pivot_linear_solver_top import lups_pkg::*; #(
	parameter int MaxOrder  = MaxOrderDef,
	parameter int ValueBits = ValueBitsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [ValueBits-1:0] value,
	input  logic                        size_in_use_we,
	input  logic [4:0]                  size_in_use_wdata,
	output logic                        strobe,
	output logic signed [ValueBits-1:0] solution,
	output logic [3:0]                  position,
	output logic                        last,
	output logic                        singular
);
	localparam int IdxBits = $clog2(MaxOrder);
	localparam int AdrBits = 2 * IdxBits;
	localparam int CntBits = $clog2(MaxOrder * MaxOrder + MaxOrder + 1);
	localparam int NBits   = $clog2(MaxOrder + 1);
	localparam int ProdBits = 2 * ValueBits;
	localparam logic signed [ValueBits-1:0] VMax = {1'b0, {(ValueBits-1){1'b1}}};
	localparam logic signed [ValueBits-1:0] VMin = {1'b1, {(ValueBits-1){1'b0}}};

	typedef enum logic [19:0] {
		S_LOAD    = 20'h00001,
		S_SCL_RD  = 20'h00002,
		S_SCL_AC  = 20'h00004,
		S_PV_RD   = 20'h00008,
		S_PV_CMP  = 20'h00010,
		S_SW_RD   = 20'h00020,
		S_SW_WR   = 20'h00040,
		S_KK_RD   = 20'h00080,
		S_FA_RD   = 20'h00100,
		S_FA_DIV  = 20'h00200,
		S_EL_RD   = 20'h00400,
		S_EL_MUL  = 20'h00800,
		S_EL_WR   = 20'h01000,
		S_FW_PERM = 20'h02000,
		S_FW_RD   = 20'h04000,
		S_FW_MUL  = 20'h08000,
		S_BK_RD   = 20'h10000,
		S_BK_MUL  = 20'h20000,
		S_BK_DIV  = 20'h40000,
		S_OUT     = 20'h80000
	} state_t;

	state_t state_q;

	logic [4:0]         size_q;
	logic [NBits-1:0]   n;
	logic [CntBits-1:0] load_q;
	logic [IdxBits-1:0] lr_q, lc_q;
	logic               sing_q;

	// memories
	logic signed [ValueBits-1:0] mat [MaxOrder*MaxOrder];
	logic signed [ValueBits-1:0] xs  [MaxOrder];
	logic [ValueBits-1:0]        scl [MaxOrder];
	logic [IdxBits-1:0]          piv [MaxOrder];

	logic signed [ValueBits-1:0] mrd_q;
	logic                        m_we;
	logic [AdrBits-1:0]          m_wa, m_ra;
	logic signed [ValueBits-1:0] m_wd;

	// loop indices and scratch
	logic [IdxBits-1:0] i_q, j_q, k_q, best_q;
	logic               found_q;
	logic [ValueBits-1:0] big_q, bx_q, bs_q;
	logic signed [ValueBits-1:0] f_q, t_q, acc_q, pkk_q;
	logic signed [ProdBits-1:0]  prod_s1;
	logic [ProdBits-1:0]         c1_s1, c2_s1;
	logic [1:0]                  cmp_ph_q;

	logic [ValueBits-1:0] mag_rd;
	assign mag_rd = mrd_q[ValueBits-1] ? ValueBits'(-mrd_q) : ValueBits'(mrd_q);

	always_comb begin
		if (size_q == '0) n = NBits'(1);
		else if ({27'd0, size_q} > 32'(MaxOrder)) n = NBits'(MaxOrder);
		else n = NBits'(size_q);
	end

	logic [IdxBits-1:0] nm1;
	assign nm1 = IdxBits'(n - 1'b1);

	function automatic logic [AdrBits-1:0] adr(input logic [IdxBits-1:0] r,
	                                           input logic [IdxBits-1:0] c);
		adr = {r, c};
	endfunction

	// rounded saturating multiply (from registered product) then subtract
	logic signed [ValueBits-1:0] mul_res;
	logic signed [ValueBits-1:0] sub_res;
	logic signed [ValueBits:0]   dif;
	always_comb begin
		logic [ProdBits-1:0] pm;
		logic [ProdBits:0]   pq;
		pm = prod_s1[ProdBits-1] ? ProdBits'(-prod_s1) : ProdBits'(prod_s1);
		pq = ({1'b0, pm} + (ProdBits+1)'(1 << (FracBits-1))) >> FracBits;
		if (pq > (ProdBits+1)'(VMax))
			mul_res = prod_s1[ProdBits-1] ? VMin : VMax;
		else
			mul_res = prod_s1[ProdBits-1] ? ValueBits'(-pq) : ValueBits'(pq);
		dif = {acc_q[ValueBits-1], acc_q} - {mul_res[ValueBits-1], mul_res};
		if (dif[ValueBits] != dif[ValueBits-1])
			sub_res = dif[ValueBits] ? VMin : VMax;
		else
			sub_res = dif[ValueBits-1:0];
	end

	// divider
	div_ctl_t dctl;
	logic     d_done;
	logic signed [ValueBits-1:0] d_num, d_den, d_quo;
	lups_div #(.ValueBits(ValueBits)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(d_num), .den(d_den),
		.done(d_done), .quo(d_quo)
	);

	logic div_go_q;
	assign dctl.go   = div_go_q;
	assign dctl.kind = (state_q == S_BK_DIV) ? DIV_SOLVE : DIV_FACTOR;
	assign d_num     = acc_q;
	assign d_den     = pkk_q;

	assign busy = (state_q != S_LOAD);

	// memory port
	always_ff @(posedge clk) begin
		if (m_we) mat[m_wa] <= m_wd;
		mrd_q <= mat[m_ra];
	end

	// next state and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			size_q   <= 5'd16;
			load_q   <= '0;
			lr_q     <= '0;
			lc_q     <= '0;
			sing_q   <= 1'b0;
			strobe   <= 1'b0;
			div_go_q <= 1'b0;
			cmp_ph_q <= '0;
		end else begin
			strobe   <= 1'b0;
			div_go_q <= 1'b0;
			if (size_in_use_we) begin
				size_q <= size_in_use_wdata;
				load_q <= '0;
				lr_q   <= '0;
				lc_q   <= '0;
				sing_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (start && !size_in_use_we) begin
						load_q <= load_q + 1'b1;
						if (load_q < CntBits'(n) * CntBits'(n)) begin
							if (lc_q == nm1) begin
								lc_q <= '0;
								lr_q <= lr_q + 1'b1;
							end else begin
								lc_q <= lc_q + 1'b1;
							end
						end else begin
							// right-hand side capture
							xs[IdxBits'(load_q - CntBits'(n) * CntBits'(n))] <= value;
						end
						if (load_q == CntBits'(n) * CntBits'(n) + CntBits'(n) - 1'b1) begin
							state_q <= S_SCL_RD;
							i_q <= '0;
							j_q <= '0;
							big_q <= '0;
						end
					end
				end
				S_SCL_RD: begin
					state_q <= S_SCL_AC;
				end
				S_SCL_AC: begin
					logic [ValueBits-1:0] nb;
					nb = (mag_rd > big_q) ? mag_rd : big_q;
					if (j_q == nm1) begin
						scl[i_q] <= nb;
						if (nb == '0) sing_q <= 1'b1;
						big_q <= '0;
						j_q <= '0;
						if (i_q == nm1) begin
							k_q <= '0;
							i_q <= '0;
							found_q <= 1'b0;
							state_q <= S_PV_RD;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_SCL_RD;
						end
					end else begin
						big_q <= nb;
						j_q <= j_q + 1'b1;
						state_q <= S_SCL_RD;
					end
				end
				S_PV_RD: begin
					if (i_q == '0 && !found_q) begin
						i_q <= k_q;
						best_q <= k_q;
					end
					cmp_ph_q <= '0;
					state_q <= S_PV_CMP;
				end
				S_PV_CMP: begin
					// phase 0: products; 1: decide
					if (cmp_ph_q == 2'd0) begin
						c1_s1 <= ProdBits'(mag_rd) * ProdBits'(bs_q);
						c2_s1 <= ProdBits'(bx_q) * ProdBits'(scl[i_q]);
						t_q <= mrd_q;
						cmp_ph_q <= 2'd1;
					end else begin
						logic [ValueBits-1:0] x;
						x = t_q[ValueBits-1] ? ValueBits'(-t_q) : ValueBits'(t_q);
						if (x != '0 && scl[i_q] != '0 && (!found_q || c1_s1 > c2_s1)) begin
							best_q <= i_q;
							found_q <= 1'b1;
							bx_q <= x;
							bs_q <= scl[i_q];
						end
						if ({1'b0, i_q} == NBits'(n - 1'b1)) begin
							j_q <= '0;
							state_q <= S_SW_RD;
							cmp_ph_q <= 2'd0;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_PV_RD;
						end
					end
				end
				S_SW_RD: begin
					piv[k_q] <= best_q;
					if (best_q == k_q) begin
						state_q <= S_KK_RD;
					end else begin
						cmp_ph_q <= cmp_ph_q + 1'b1;
						if (cmp_ph_q == 2'd1) t_q <= mrd_q;
						if (cmp_ph_q == 2'd2) begin
							cmp_ph_q <= '0;
							state_q <= S_SW_WR;
						end
					end
				end
				S_SW_WR: begin
					cmp_ph_q <= cmp_ph_q + 1'b1;
					if (cmp_ph_q == 2'd1) begin
						cmp_ph_q <= '0;
						if (j_q == nm1) begin
							scl[best_q] <= scl[k_q];
							state_q <= S_KK_RD;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_SW_RD;
						end
					end
				end
				S_KK_RD: begin
					cmp_ph_q <= cmp_ph_q + 1'b1;
					if (cmp_ph_q == 2'd1) begin
						cmp_ph_q <= '0;
						pkk_q <= (mrd_q == '0) ? ValueBits'(1) : mrd_q;
						if (k_q == nm1) begin
							i_q <= '0;
							j_q <= '0;
							state_q <= S_FW_PERM;
						end else begin
							i_q <= k_q + 1'b1;
							state_q <= S_FA_RD;
						end
					end
				end
				S_FA_RD: begin
					cmp_ph_q <= cmp_ph_q + 1'b1;
					if (cmp_ph_q == 2'd1) begin
						cmp_ph_q <= '0;
						acc_q <= mrd_q;
						div_go_q <= 1'b1;
						state_q <= S_FA_DIV;
					end
				end
				S_FA_DIV: begin
					if (d_done) begin
						f_q <= d_quo;
						j_q <= k_q + 1'b1;
						state_q <= S_EL_RD;
					end
				end
				S_EL_RD: begin
					// read a[k][j] then a[i][j]
					cmp_ph_q <= cmp_ph_q + 1'b1;
					if (cmp_ph_q == 2'd1) t_q <= mrd_q;
					if (cmp_ph_q == 2'd2) begin
						cmp_ph_q <= '0;
						acc_q <= mrd_q;
						prod_s1 <= ProdBits'(f_q) * ProdBits'(t_q);
						state_q <= S_EL_MUL;
					end
				end
				S_EL_MUL: begin
					state_q <= S_EL_WR;
				end
				S_EL_WR: begin
					if (j_q == nm1) begin
						if (i_q == nm1) begin
							k_q <= k_q + 1'b1;
							i_q <= '0;
							found_q <= 1'b0;
							state_q <= S_PV_RD;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_FA_RD;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_EL_RD;
					end
				end
				S_FW_PERM: begin
					acc_q <= xs[piv[i_q]];
					xs[piv[i_q]] <= xs[i_q];
					j_q <= '0;
					cmp_ph_q <= '0;
					state_q <= (i_q == '0) ? S_FW_MUL : S_FW_RD;
				end
				S_FW_RD: begin
					cmp_ph_q <= cmp_ph_q + 1'b1;
					if (cmp_ph_q == 2'd1) begin
						cmp_ph_q <= 2'd2;
						prod_s1 <= ProdBits'(mrd_q) * ProdBits'(xs[j_q]);
					end
					if (cmp_ph_q == 2'd2) begin
						acc_q <= sub_res;
						cmp_ph_q <= '0;
						if (j_q + 1'b1 == i_q) state_q <= S_FW_MUL;
						else j_q <= j_q + 1'b1;
					end
				end
				S_FW_MUL: begin
					xs[i_q] <= acc_q;
					if (i_q == nm1) begin
						acc_q <= (i_q == nm1) ? xs[nm1] : acc_q;
						i_q <= nm1;
						state_q <= S_BK_RD;
						j_q <= nm1;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_FW_PERM;
					end
				end
				S_BK_RD: begin
					// j_q == i_q: fetch x[i] and pivot; else accumulate
					cmp_ph_q <= cmp_ph_q + 1'b1;
					if (j_q == i_q) begin
						if (cmp_ph_q == 2'd0) acc_q <= xs[i_q];
						if (cmp_ph_q == 2'd1) begin
							cmp_ph_q <= '0;
							pkk_q <= mrd_q;
							if (i_q == nm1) begin
								div_go_q <= 1'b1;
								state_q <= S_BK_DIV;
							end else begin
								j_q <= i_q + 1'b1;
							end
						end
					end else begin
						if (cmp_ph_q == 2'd1)
							prod_s1 <= ProdBits'(mrd_q) * ProdBits'(xs[j_q]);
						if (cmp_ph_q == 2'd2) begin
							acc_q <= sub_res;
							cmp_ph_q <= '0;
							if (j_q == nm1) begin
								div_go_q <= 1'b1;
								state_q <= S_BK_MUL;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
					end
				end
				S_BK_MUL: begin
					state_q <= S_BK_DIV;
				end
				S_BK_DIV: begin
					if (d_done) begin
						xs[i_q] <= d_quo;
						if (i_q == '0) begin
							i_q <= '0;
							state_q <= S_OUT;
						end else begin
							i_q <= i_q - 1'b1;
							j_q <= i_q - 1'b1;
							cmp_ph_q <= '0;
							state_q <= S_BK_RD;
						end
					end
				end
				S_OUT: begin
					strobe   <= 1'b1;
					solution <= xs[i_q];
					position <= 4'(i_q);
					last     <= (i_q == nm1);
					singular <= sing_q;
					if (i_q == nm1) begin
						load_q <= '0;
						lr_q <= '0;
						lc_q <= '0;
						sing_q <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// memory address and write selection
	always_comb begin
		m_we = 1'b0;
		m_wa = adr(lr_q, lc_q);
		m_wd = value;
		m_ra = adr(i_q, j_q);
		unique case (state_q)
			S_LOAD: begin
				m_we = start && !size_in_use_we && (load_q < CntBits'(n) * CntBits'(n));
			end
			S_PV_RD: m_ra = adr((i_q == '0 && !found_q) ? k_q : i_q, k_q);
			S_PV_CMP: m_ra = adr(i_q, k_q);
			S_SW_RD: m_ra = (cmp_ph_q == 2'd0) ? adr(best_q, j_q) : adr(k_q, j_q);
			S_SW_WR: begin
				m_we = 1'b1;
				m_wa = (cmp_ph_q == 2'd0) ? adr(best_q, j_q) : adr(k_q, j_q);
				m_wd = (cmp_ph_q == 2'd0) ? mrd_q : t_q;
			end
			S_KK_RD: begin
				m_ra = adr(k_q, k_q);
				m_we = (cmp_ph_q == 2'd1) && (mrd_q == '0);
				m_wa = adr(k_q, k_q);
				m_wd = ValueBits'(1);
			end
			S_FA_RD: m_ra = adr(i_q, k_q);
			S_FA_DIV: begin
				m_we = d_done;
				m_wa = adr(i_q, k_q);
				m_wd = d_quo;
			end
			S_EL_RD: m_ra = (cmp_ph_q == 2'd0) ? adr(k_q, j_q) : adr(i_q, j_q);
			S_EL_WR: begin
				m_we = 1'b1;
				m_wa = adr(i_q, j_q);
				m_wd = sub_res;
			end
			S_BK_RD: m_ra = adr(i_q, j_q);
			default: ;
		endcase
	end

endmodule
